[sv/css_pkg.sv]
// Shared types and constants for the cocktail shaker sorter.
// Holds field widths and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package css_pkg;

    localparam int VALUE_W = 16;
    localparam int STEP_W  = 9;

    localparam logic [STEP_W-1:0] STEP_MAX = 9'd511;

    typedef struct packed {
        logic wr_item;
        logic wr_step;
        logic wr_carry;
        logic rd_en;
        logic carry_ld;
        logic step;
        logic dir_bwd;
        logic clr_swap;
        logic out_load;
        logic out_last;
    } css_cmd_t;

    typedef struct packed {
        logic swap;
        logic out_free;
    } css_sts_t;

endpackage

`default_nettype wire

[sv/css_in_if.sv]
// Input channel of the sorter: one value to load per beat.
// Depends on css_pkg for the field width.
`default_nettype none

interface css_in_if
    import css_pkg::*;
();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] item_value;

    modport source (output valid, output item_value, input ready);
    modport sink   (input valid, input item_value, output ready);

endinterface

`default_nettype wire

[sv/css_out_if.sv]
// Output channel of the sorter: one sorted value per beat with step total and last flag.
// Depends on css_pkg for the field widths.
`default_nettype none

interface css_out_if
    import css_pkg::*;
();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sorted_value;
    logic [STEP_W-1:0]  step_total;
    logic               last_out;

    modport source (output valid, output sorted_value, output step_total,
                    output last_out, input ready);
    modport sink   (input valid, input sorted_value, input step_total,
                    input last_out, output ready);

endinterface

`default_nettype wire

[sv/cocktail_shaker_sorter.sv]
// Cocktail shaker sorter: loads LIST_LEN values, one per beat, then sorts and streams them.
// A pass makes one compare per cycle on the store port.
// Throughput: one load beat per cycle; readout one beat per cycle while the output register is free.
// Reset: rst_n clears control and the swap count; the value store is not cleared.
`default_nettype none

module cocktail_shaker_sorter
    import css_pkg::*;
#(
    parameter int LIST_LEN   = 32,
    parameter int VALUE_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    css_in_if.sink     item,
    css_out_if.source  sorted
);

    localparam int AW = $clog2(LIST_LEN);

    css_cmd_t      cmd;
    css_sts_t      sts;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          in_ready;

    assign item.ready = in_ready;

    css_ctrl #(
        .LIST_LEN (LIST_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    css_datapath #(
        .LIST_LEN   (LIST_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .item_value   (item.item_value),
        .out_ready    (sorted.ready),
        .sts          (sts),
        .out_valid    (sorted.valid),
        .sorted_value (sorted.sorted_value),
        .step_total   (sorted.step_total),
        .last_out     (sorted.last_out)
    );

endmodule

`default_nettype wire

[sv/css_datapath.sv]
// Datapath of the sorter: value store, carry register, compare, swap counter
// and output register. Driven by css_ctrl through css_cmd_t; depends on css_pkg.
`default_nettype none

module css_datapath
    import css_pkg::*;
#(
    parameter int LIST_LEN   = 32,
    parameter int VALUE_BITS = 16,
    localparam int AW        = $clog2(LIST_LEN)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire css_cmd_t           cmd,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [VALUE_W-1:0] item_value,
    input  wire logic               out_ready,
    output css_sts_t                sts,
    output logic                    out_valid,
    output logic [VALUE_W-1:0]      sorted_value,
    output logic [STEP_W-1:0]       step_total,
    output logic                    last_out
);

    logic [VALUE_BITS-1:0] mem [LIST_LEN];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] carry_reg;
    logic [VALUE_BITS-1:0] carry_next;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;
    logic                  swap;
    logic [STEP_W-1:0]     swap_reg;
    logic [STEP_W-1:0]     swap_next;
    logic [STEP_W-1:0]     total;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    value_out_reg;
    logic [STEP_W-1:0]     total_out_reg;
    logic                  last_out_reg;

    assign swap = cmd.dir_bwd ? (rd_data_reg > carry_reg) : (carry_reg > rd_data_reg);
    assign sts.swap     = swap;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign wr_en = cmd.wr_item || cmd.wr_step || cmd.wr_carry;

    always_comb
    begin
        priority if (cmd.wr_item)
        begin
            wr_data = VALUE_BITS'(item_value);
        end
        else if (cmd.wr_step)
        begin
            wr_data = swap ? rd_data_reg : carry_reg;
        end
        else
        begin
            wr_data = carry_reg;
        end
    end

    always_comb
    begin
        carry_next = carry_reg;
        if (cmd.carry_ld)
        begin
            carry_next = rd_data_reg;
        end
        else if (cmd.step && !swap)
        begin
            carry_next = rd_data_reg;
        end
    end

    always_comb
    begin
        swap_next = swap_reg;
        if (cmd.clr_swap)
        begin
            swap_next = '0;
        end
        else if (cmd.step && swap && (swap_reg != STEP_MAX))
        begin
            swap_next = swap_reg + STEP_W'(1);
        end
    end

    assign total = (swap_reg == STEP_MAX) ? STEP_MAX : swap_reg + STEP_W'(1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        carry_reg <= carry_next;
        if (cmd.out_load)
        begin
            value_out_reg <= VALUE_W'(rd_data_reg);
            total_out_reg <= total;
            last_out_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            swap_reg      <= swap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = value_out_reg;
    assign step_total   = total_out_reg;
    assign last_out     = last_out_reg;

`ifndef SYNTHESIS
    a_swap_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_swap |=> swap_reg >= $past(swap_reg))
        else $error("swap count went backward without a clear");

    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("output register loaded but not valid");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            (out_valid_reg && $stable({value_out_reg, total_out_reg, last_out_reg})))
        else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

[sv/css_ctrl.sv]
// Controller of the sorter: load, forward and backward passes, and readout.
// Owns the pass bounds and index; drives css_datapath via css_cmd_t. Depends on css_pkg.
`default_nettype none

module css_ctrl
    import css_pkg::*;
#(
    parameter int LIST_LEN = 32,
    localparam int AW      = $clog2(LIST_LEN)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire css_sts_t      sts,
    output css_cmd_t           cmd,
    output logic [AW-1:0]      wr_addr,
    output logic [AW-1:0]      rd_addr
);

    typedef enum logic [10:0] {
        ST_LOAD    = 11'b000_0000_0001,
        ST_F_PRIME = 11'b000_0000_0010,
        ST_F_LOAD  = 11'b000_0000_0100,
        ST_F_RUN   = 11'b000_0000_1000,
        ST_F_END   = 11'b000_0001_0000,
        ST_B_PRIME = 11'b000_0010_0000,
        ST_B_LOAD  = 11'b000_0100_0000,
        ST_B_RUN   = 11'b000_1000_0000,
        ST_B_END   = 11'b001_0000_0000,
        ST_OUT_RD  = 11'b010_0000_0000,
        ST_OUT_WR  = 11'b100_0000_0000
    } css_state_t;

    localparam logic [AW-1:0] LAST_IDX = AW'(LIST_LEN - 1);

    css_state_t    state_reg;
    css_state_t    state_next;
    logic [AW-1:0] lo_reg;
    logic [AW-1:0] lo_next;
    logic [AW-1:0] hi_reg;
    logic [AW-1:0] hi_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          moved_reg;
    logic          moved_next;
    logic [AW-1:0] idx_inc;
    logic [AW-1:0] idx_dec;
    logic [AW:0]   idx_p2;
    logic [AW:0]   idx_m2;
    logic [AW:0]   lo_p1;

    assign idx_inc = idx_reg + AW'(1);
    assign idx_dec = idx_reg - AW'(1);
    assign idx_p2  = {1'b0, idx_reg} + (AW+1)'(2);
    assign idx_m2  = {1'b0, idx_reg} - (AW+1)'(2);
    assign lo_p1   = {1'b0, lo_reg} + (AW+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        moved_next = moved_reg;
        cmd        = '0;
        wr_addr    = idx_reg;
        rd_addr    = idx_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_item = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        cmd.clr_swap = 1'b1;
                        lo_next      = '0;
                        hi_next      = LAST_IDX;
                        idx_next     = '0;
                        state_next   = ST_F_PRIME;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            ST_F_PRIME:
            begin
                if (lo_reg >= hi_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = lo_reg;
                    state_next = ST_F_LOAD;
                end
            end
            ST_F_LOAD:
            begin
                cmd.carry_ld = 1'b1;
                cmd.rd_en    = 1'b1;
                rd_addr      = lo_p1[AW-1:0];
                idx_next     = lo_reg;
                moved_next   = 1'b0;
                state_next   = ST_F_RUN;
            end
            ST_F_RUN:
            begin
                cmd.step    = 1'b1;
                cmd.wr_step = 1'b1;
                moved_next  = moved_reg || sts.swap;
                if (idx_p2 <= {1'b0, hi_reg})
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_p2[AW-1:0];
                end
                idx_next = idx_inc;
                if (idx_inc == hi_reg)
                begin
                    state_next = ST_F_END;
                end
            end
            ST_F_END:
            begin
                cmd.wr_carry = 1'b1;
                wr_addr      = hi_reg;
                if (!moved_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    hi_next    = hi_reg - AW'(1);
                    state_next = ST_B_PRIME;
                end
            end
            ST_B_PRIME:
            begin
                if (hi_reg <= lo_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = hi_reg;
                    state_next = ST_B_LOAD;
                end
            end
            ST_B_LOAD:
            begin
                cmd.carry_ld = 1'b1;
                cmd.rd_en    = 1'b1;
                rd_addr      = hi_reg - AW'(1);
                idx_next     = hi_reg;
                moved_next   = 1'b0;
                state_next   = ST_B_RUN;
            end
            ST_B_RUN:
            begin
                cmd.step    = 1'b1;
                cmd.dir_bwd = 1'b1;
                cmd.wr_step = 1'b1;
                moved_next  = moved_reg || sts.swap;
                if ({1'b0, idx_reg} > lo_p1)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_m2[AW-1:0];
                end
                idx_next = idx_dec;
                if (idx_dec == lo_reg)
                begin
                    state_next = ST_B_END;
                end
            end
            ST_B_END:
            begin
                cmd.wr_carry = 1'b1;
                wr_addr      = lo_reg;
                lo_next      = lo_p1[AW-1:0];
                if (!moved_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_F_PRIME;
                end
            end
            ST_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_OUT_WR;
            end
            ST_OUT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_inc;
                        idx_next  = idx_inc;
                    end
                end
            end
            default:
            begin
                idx_next   = '0;
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            lo_reg    <= '0;
            hi_reg    <= LAST_IDX;
            idx_reg   <= '0;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            moved_reg <= moved_next;
        end
    end

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_step && cmd.rd_en) |-> (wr_addr != rd_addr))
        else $error("pass step reads the entry it writes");

    a_bounds_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_RUN || state_reg == ST_B_RUN) |-> (lo_reg < hi_reg))
        else $error("pass running with closed bounds");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten while held");
`endif

endmodule

`default_nettype wire
